// ===== rtl/pife_pkg.sv =====
// Shared types, constants and command/status structs for the packet interval
// frequency error block. No dependencies.
package pife_pkg;

    localparam int WindowDepth = 512;
    localparam int MaxTurns    = 16;
    localparam int IdxW        = $clog2(WindowDepth);
    localparam int TurnW       = $clog2(MaxTurns + 1);

    localparam logic [31:0] WrapTicks = 32'h0000_FFFF;

    localparam logic [1:0] CFG_NOMINAL   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_REFSUM    = 2'd2;

    localparam logic [1:0] ST_FIRST   = 2'd0;
    localparam logic [1:0] ST_ACCEPT  = 2'd1;
    localparam logic [1:0] ST_OUTLIER = 2'd2;

    // Divider operand selects
    localparam logic [1:0] DIV_TURNS = 2'd0;
    localparam logic [1:0] DIV_RESID = 2'd1;
    localparam logic [1:0] DIV_SPLIT = 2'd2;
    localparam logic [1:0] DIV_ERROR = 2'd3;

    typedef struct packed {
        logic       capture;      // register capture, form interval
        logic       tick;         // count an overflow
        logic       div_start;
        logic [1:0] div_sel;
        logic       turns_load;   // latch rounded quotient
        logic       split_init;   // rem <= interval, i <= turns
        logic       rd_issue;     // read old window entry
        logic       push;         // write entry, update sum
        logic       mul_start;
        logic       err_load;
        logic       out_load;
        logic [1:0] out_status;
    } pife_cmd_t;

    typedef struct packed {
        logic first_seen;
        logic div_done;
        logic mul_done;
        logic reject;             // turns zero/too large or residual too big
        logic split_last;         // i == 1
        logic filled;
    } pife_sts_t;

endpackage

// ===== rtl/pife_datapath.sv =====
// Datapath: interval, shared shift-subtract divider, window memory and sum,
// shift-add multiplier for the error term. Depends on pife_pkg.
module pife_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pife_pkg::pife_cmd_t  cmd,
    output pife_pkg::pife_sts_t  sts,
    input  logic [15:0]          cap_in,
    input  logic [23:0]          nominal_period,
    input  logic [23:0]          outlier_threshold,
    input  logic [31:0]          reference_sum,
    output logic [1:0]           o_status,
    output logic [31:0]          o_interval,
    output logic [4:0]           o_turns,
    output logic                 o_full,
    output logic [31:0]          o_sum,
    output logic [31:0]          o_error
);

    logic [31:0] ovf_reg;
    logic [15:0] prev_reg;
    logic        seen_reg;
    logic [31:0] interval_reg;
    logic [31:0] sum_reg;
    logic [pife_pkg::IdxW-1:0] widx_reg;
    logic        filled_reg;
    logic [31:0] err_reg;
    logic [4:0]  turns_reg;
    logic [31:0] rem_reg;
    logic [6:0]  i_reg;
    logic [31:0] old_reg;
    logic [31:0] win_mem [pife_pkg::WindowDepth];

    // Divider: 64-bit dividend, 64-bit divisor, one bit per cycle
    logic [63:0] dvd_reg, dvs_reg, quo_reg, rmd_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg, dneg_reg;
    logic [63:0] dvd_in, dvs_in;
    logic        dneg_in;
    logic [63:0] rtrial;
    logic [64:0] rsh;

    // Multiplier: |diff| * 1e9, one bit per cycle
    logic [63:0] macc_reg, mcand_reg;
    logic [31:0] mplier_reg;
    logic [5:0]  mcnt_reg;
    logic        mbusy_reg;

    logic [31:0] p_eff, ref_eff, new_interval, d_diff, abs_diff;
    logic        d_neg;

    assign p_eff   = (nominal_period == 24'd0) ? 32'd1 : {8'd0, nominal_period};
    assign ref_eff = (reference_sum == 32'd0) ? 32'd1 : reference_sum;
    assign d_diff  = sum_reg - ref_eff;
    assign d_neg   = d_diff[31];
    assign abs_diff = d_neg ? (~d_diff + 32'd1) : d_diff;

    // Interval since last capture
    always_comb begin
        if (ovf_reg != 32'd0)
            new_interval = (pife_pkg::WrapTicks - {16'd0, prev_reg})
                + (ovf_reg - 32'd1) * pife_pkg::WrapTicks + {16'd0, cap_in};
        else
            new_interval = {16'd0, cap_in} - {16'd0, prev_reg};
    end

    // Select divider operands
    always_comb begin
        dneg_in = 1'b0;
        case (cmd.div_sel)
            pife_pkg::DIV_TURNS: begin
                dvd_in = {31'd0, interval_reg, 1'b0} + {32'd0, p_eff};
                dvs_in = {31'd0, p_eff, 1'b0};
            end
            pife_pkg::DIV_RESID: begin
                dvd_in = {32'd0, interval_reg};
                dvs_in = {59'd0, turns_reg};
            end
            pife_pkg::DIV_SPLIT: begin
                dvd_in = {32'd0, rem_reg};
                dvs_in = {57'd0, i_reg};
            end
            default: begin
                dvd_in  = macc_reg;
                dvs_in  = {32'd0, ref_eff};
                dneg_in = d_neg;
            end
        endcase
    end

    assign rsh    = {rmd_reg, dvd_reg[63]};
    assign rtrial = rsh[63:0] - dvs_reg;

    // Iterate the divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= 7'd0;
        end else if (cmd.div_start) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= 7'd64;
            dvd_reg   <= dvd_in;
            dvs_reg   <= dvs_in;
            dneg_reg  <= dneg_in;
            quo_reg   <= 64'd0;
            rmd_reg   <= 64'd0;
        end else if (dbusy_reg) begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            if (!rsh[64] && rsh[63:0] >= dvs_reg) begin
                rmd_reg <= rtrial;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rmd_reg <= rsh[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 7'd1;
            if (dcnt_reg == 7'd1)
                dbusy_reg <= 1'b0;
        end
    end

    // Iterate the multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= 6'd0;
        end else if (cmd.mul_start) begin
            mbusy_reg  <= 1'b1;
            mcnt_reg   <= 6'd32;
            macc_reg   <= 64'd0;
            mcand_reg  <= {32'd0, abs_diff};
            mplier_reg <= 32'd1000000000;
        end else if (mbusy_reg) begin
            if (mplier_reg[0])
                macc_reg <= macc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[62:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[31:1]};
            mcnt_reg   <= mcnt_reg - 6'd1;
            if (mcnt_reg == 6'd1)
                mbusy_reg <= 1'b0;
        end
    end

    assign sts.div_done   = !dbusy_reg && !cmd.div_start;
    assign sts.mul_done   = !mbusy_reg && !cmd.mul_start;
    assign sts.first_seen = seen_reg;
    assign sts.filled     = filled_reg;
    assign sts.split_last = (i_reg == 7'd1);
    assign sts.reject     = (turns_reg == 5'd0)
        || (rmd_reg[31:0] >= {8'd0, outlier_threshold});

    // Window memory
    always_ff @(posedge aclk) begin
        if (cmd.rd_issue)
            old_reg <= win_mem[widx_reg];
        if (cmd.push)
            win_mem[widx_reg] <= quo_reg[31:0];
    end

    // Capture state, turns, split loop, window sum and error term
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg    <= 32'd0;
            prev_reg   <= 16'd0;
            seen_reg   <= 1'b0;
            sum_reg    <= 32'd0;
            widx_reg   <= '0;
            filled_reg <= 1'b0;
            err_reg    <= 32'd0;
        end else begin
            if (cmd.tick)
                ovf_reg <= ovf_reg + 32'd1;
            if (cmd.capture) begin
                interval_reg <= seen_reg ? new_interval : 32'd0;
                ovf_reg      <= 32'd0;
                prev_reg     <= cap_in;
                seen_reg     <= 1'b1;
            end
            if (cmd.turns_load) begin
                if (quo_reg == 64'd0 || quo_reg > 64'(pife_pkg::MaxTurns))
                    turns_reg <= 5'd0;
                else
                    turns_reg <= quo_reg[4:0];
            end
            if (cmd.split_init) begin
                rem_reg <= interval_reg;
                i_reg   <= {2'd0, turns_reg};
            end
            if (cmd.push) begin
                sum_reg <= (filled_reg ? sum_reg - old_reg : sum_reg) + quo_reg[31:0];
                rem_reg <= rem_reg - quo_reg[31:0];
                i_reg   <= i_reg - 7'd1;
                if (widx_reg == pife_pkg::IdxW'(pife_pkg::WindowDepth - 1)) begin
                    widx_reg   <= '0;
                    filled_reg <= 1'b1;
                end else begin
                    widx_reg <= widx_reg + 1'b1;
                end
            end
            if (cmd.err_load) begin
                if (dneg_reg) begin
                    if (quo_reg > 64'd2147483648)
                        err_reg <= 32'h8000_0000;
                    else
                        err_reg <= ~quo_reg[31:0] + 32'd1;
                end else begin
                    if (quo_reg > 64'd2147483647)
                        err_reg <= 32'h7FFF_FFFF;
                    else
                        err_reg <= quo_reg[31:0];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_status   <= cmd.out_status;
            o_interval <= interval_reg;
            o_turns    <= (cmd.out_status == pife_pkg::ST_ACCEPT) ? turns_reg : 5'd0;
            o_full     <= filled_reg;
            o_sum      <= sum_reg;
            o_error    <= err_reg;
        end
    end

endmodule

// ===== rtl/pife_ctrl.sv =====
// Controller state machine sequencing the datapath for each transaction.
// Depends on pife_pkg.
module pife_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pife_pkg::pife_cmd_t  cmd,
    input  pife_pkg::pife_sts_t  sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TURNS  = 4'd1;
    localparam logic [3:0] S_RESID  = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_SPLIT  = 4'd4;
    localparam logic [3:0] S_PUSH   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_EDIV   = 4'd7;
    localparam logic [3:0] S_ELOAD  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_STARTT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       mvalid_reg, mvalid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mvalid_reg;

    // Next-state and command decode
    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        mvalid_next = mvalid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_mode) begin
                        cmd.tick = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        if (sts.first_seen) begin
                            state_next = S_STARTT;
                        end else begin
                            status_next = pife_pkg::ST_FIRST;
                            state_next  = S_OUT;
                        end
                    end
                end
            end
            S_STARTT: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = pife_pkg::DIV_TURNS;
                state_next    = S_TURNS;
            end
            S_TURNS: begin
                if (sts.div_done) begin
                    cmd.turns_load = 1'b1;
                    state_next     = S_RESID;
                end
            end
            S_RESID: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = pife_pkg::DIV_RESID;
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                if (sts.div_done) begin
                    if (sts.reject) begin
                        status_next = pife_pkg::ST_OUTLIER;
                        state_next  = S_OUT;
                    end else begin
                        status_next    = pife_pkg::ST_ACCEPT;
                        cmd.split_init = 1'b1;
                        state_next     = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = pife_pkg::DIV_SPLIT;
                cmd.rd_issue  = 1'b1;
                state_next    = S_PUSH;
            end
            S_PUSH: begin
                if (sts.div_done) begin
                    cmd.push = 1'b1;
                    if (!sts.split_last)
                        state_next = S_SPLIT;
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (sts.filled) begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_EDIV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_EDIV: begin
                if (sts.mul_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = pife_pkg::DIV_ERROR;
                    state_next    = S_ELOAD;
                end
            end
            S_ELOAD: begin
                if (sts.div_done) begin
                    cmd.err_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = status_reg;
                    mvalid_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= pife_pkg::ST_FIRST;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ===== rtl/packet_interval_frequency_error_top.sv =====
// Bit-serial sequence: a tick gives no result; the first capture is reported as FIRST with
// no division; an outlier after the turns and residual divisions; an accepted capture adds
// a split division per turn, and an error multiply and divide once the window is full.
// Throughput: one transaction at a time; s_ready returns the cycle after the result is
// loaded. Reset (aresetn low, synchronous) clears control, sum, counters and
// configuration to defaults; window memory is not cleared.
module packet_interval_frequency_error_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_capture_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_interval,
    output logic [4:0]  m_turns,
    output logic        m_window_full,
    output logic [31:0] m_window_sum,
    output logic signed [31:0] m_error_ppb
);

    logic [23:0] nominal_reg, thresh_reg;
    logic [31:0] refsum_reg;
    pife_pkg::pife_cmd_t cmd;
    pife_pkg::pife_sts_t sts;
    logic [31:0] err_w;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg <= 24'd3932100;
            thresh_reg  <= 24'd3840;
            refsum_reg  <= 32'd2013235200;
        end else if (cfg_we) begin
            case (cfg_index)
                pife_pkg::CFG_NOMINAL:   nominal_reg <= cfg_data[23:0];
                pife_pkg::CFG_THRESHOLD: thresh_reg  <= cfg_data[23:0];
                pife_pkg::CFG_REFSUM:    refsum_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    pife_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    pife_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cap_in            (s_capture_value),
        .nominal_period    (nominal_reg),
        .outlier_threshold (thresh_reg),
        .reference_sum     (refsum_reg),
        .o_status          (m_status),
        .o_interval        (m_interval),
        .o_turns           (m_turns),
        .o_full            (m_window_full),
        .o_sum             (m_window_sum),
        .o_error           (err_w)
    );

    assign m_error_ppb = $signed(err_w);

endmodule
